// ===== rtl/tlfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the three-level feedback scheduler.
// Used by tlfs_queues and three_level_feedback_scheduler_core; no dependencies.
package tlfs_pkg;

	localparam int MAX_PROCESSES_DEF = 64;
	localparam int PID_W             = 6;
	localparam int TICKS_W           = 24;
	localparam int TIME_W            = 26;

	localparam logic [TICKS_W-1:0] TICKS_RESET  = 24'd2000000;
	localparam logic [TIME_W-1:0]  MARGIN_RESET = 26'd1000000;
	localparam logic [TIME_W-1:0]  ELAPSED_MAX  = 26'h3FFFFFF;

	typedef logic [1:0] lvl_t;

	localparam lvl_t LVL_TOP = 2'd0;
	localparam lvl_t LVL_MID = 2'd1;
	localparam lvl_t LVL_LOW = 2'd2;

	typedef enum logic [2:0] {
		MODE_ADMIT    = 3'd0,
		MODE_DISPATCH = 3'd1,
		MODE_TICK     = 3'd2,
		MODE_IO_START = 3'd3,
		MODE_END      = 3'd4,
		MODE_IO_DONE  = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		ST_ADMITTED   = 4'd0,
		ST_DISPATCHED = 4'd1,
		ST_EMPTY      = 4'd2,
		ST_PREEMPTED  = 4'd3,
		ST_BLOCKED    = 4'd4,
		ST_ENDED      = 4'd5,
		ST_REQUEUED   = 4'd6,
		ST_NOCHANGE   = 4'd7,
		ST_ERROR      = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_QREAD,
		S_EXEC
	} state_t;

	typedef enum logic {
		REG_TICKS  = 1'b0,
		REG_MARGIN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic push;
		lvl_t push_lvl;
		logic pop;
		lvl_t pop_lvl;
	} qcmd_t;

	typedef struct packed {
		logic [2:0] nonempty;
		logic [2:0] full;
		lvl_t       top_lvl;
	} qstat_t;

	function automatic logic [TIME_W-1:0] quantum(input logic [TICKS_W-1:0] ticks,
			input lvl_t lvl);
		logic [TIME_W-1:0] q;
		case (lvl)
			LVL_TOP: q = {2'b00, ticks};
			LVL_MID: q = {1'b0, ticks, 1'b0};
			default: q = {ticks, 2'b00};
		endcase
		return q;
	endfunction

endpackage

// ===== rtl/tlfs_queues.sv =====
`timescale 1ns / 1ps
// Three ready FIFOs in one synchronous store, with head and fill registers per level.
// Depends on tlfs_pkg.
module tlfs_queues #(
	parameter int MAX_PROCESSES = tlfs_pkg::MAX_PROCESSES_DEF,
	parameter int IW            = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  tlfs_pkg::qcmd_t   cmd,
	input  logic [IW-1:0]     push_id,
	output logic [IW-1:0]     rd_id,
	output tlfs_pkg::qstat_t  stat
);

	localparam int CW    = $clog2(MAX_PROCESSES + 1);
	localparam int DEPTH = 3 * MAX_PROCESSES;
	localparam int AW    = $clog2(DEPTH);

	logic [IW-1:0] mem [DEPTH];
	logic [IW-1:0] head_q [3];
	logic [CW-1:0] cnt_q [3];
	logic [IW-1:0] rd_q;

	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [IW:0]   tail_sum;
	logic [IW:0]   tail_wrap;
	logic          push_ok;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			stat.nonempty[l] = (cnt_q[l] != '0);
			stat.full[l]     = (cnt_q[l] == CW'(MAX_PROCESSES));
		end
		if (stat.nonempty[0]) begin
			stat.top_lvl = tlfs_pkg::LVL_TOP;
		end else if (stat.nonempty[1]) begin
			stat.top_lvl = tlfs_pkg::LVL_MID;
		end else begin
			stat.top_lvl = tlfs_pkg::LVL_LOW;
		end
		raddr = AW'(stat.top_lvl) * AW'(MAX_PROCESSES) + AW'(head_q[stat.top_lvl]);
		tail_sum  = (IW+1)'(head_q[cmd.push_lvl]) + (IW+1)'(cnt_q[cmd.push_lvl]);
		tail_wrap = (tail_sum >= (IW+1)'(MAX_PROCESSES)) ?
			tail_sum - (IW+1)'(MAX_PROCESSES) : tail_sum;
		waddr   = AW'(cmd.push_lvl) * AW'(MAX_PROCESSES) + AW'(tail_wrap[IW-1:0]);
		push_ok = cmd.push && !stat.full[cmd.push_lvl];
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[waddr] <= push_id;
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	assign rd_id = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 3; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			for (int l = 0; l < 3; l++) begin
				if (cmd.pop && cmd.pop_lvl == tlfs_pkg::lvl_t'(l)) begin
					head_q[l] <= (head_q[l] == IW'(MAX_PROCESSES - 1)) ? '0 : head_q[l] + 1'b1;
				end
				if (push_ok && cmd.push_lvl == tlfs_pkg::lvl_t'(l) &&
						!(cmd.pop && cmd.pop_lvl == tlfs_pkg::lvl_t'(l))) begin
					cnt_q[l] <= cnt_q[l] + 1'b1;
				end else if (!(push_ok && cmd.push_lvl == tlfs_pkg::lvl_t'(l)) &&
						cmd.pop && cmd.pop_lvl == tlfs_pkg::lvl_t'(l)) begin
					cnt_q[l] <= cnt_q[l] - 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/three_level_feedback_scheduler_core.sv =====
`timescale 1ns / 1ps
// Top level of the three-level feedback scheduler: event channel, result channel,
// register port and the process table. Depends on tlfs_pkg and tlfs_queues.
//
// Usage:
//   Input transfers carry one event: s_tuser is the mode (admit, dispatch, tick,
//   IO start, process ended, IO done), s_tdata the process id used by IO done.
//   Every event gives exactly one result transfer: m_tuser is the status,
//   m_tdata the process id, its level, the granted quantum and elapsed ticks.
//   The register port holds ticks_per_unit at 0x0 and promote_margin_ticks at 0x4;
//   write it only while no event is in flight.
//   The result is registered when the event commits in S_EXEC; a dispatch
//   that finds a waiting process first passes S_QREAD (queue store read, then
//   process table read). The next event is accepted only in S_IDLE, after the
//   last one has committed.
//   The result sits in an output register: while the receiver stalls the block
//   still accepts the next event, and holds its commit until the register frees.
//   Reset empties the queues, clears the process count and the running process
//   and loads the register defaults; the stores themselves are not swept.
module three_level_feedback_scheduler_core #(
	parameter int MAX_PROCESSES = tlfs_pkg::MAX_PROCESSES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] process_id, [7:6] zero
	input  logic [2:0]  s_tuser,   // [2:0] mode
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [5:0] process_id_out, [7:6] level,
	                               // [33:8] quantum_ticks, [59:34] elapsed_ticks, [63:60] zero
	output logic [3:0]  m_tuser,   // [3:0] status
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CW    = $clog2(MAX_PROCESSES + 1);
	localparam int PW    = tlfs_pkg::PID_W;
	localparam int TW    = tlfs_pkg::TIME_W;

	tlfs_pkg::state_t state_q, state_nxt;
	tlfs_pkg::mode_t  mode_q;
	logic [PW-1:0]    pid_q;

	logic [23:0]      ticks_q;
	logic [TW-1:0]    margin_q;

	logic [IW-1:0]    run_id_q;
	logic             run_valid_q;
	tlfs_pkg::lvl_t   run_lvl_q;
	logic [TW-1:0]    elapsed_q;
	logic [CW-1:0]    proc_cnt_q;

	logic                m_tvalid_q;
	tlfs_pkg::status_t   out_status_q;
	logic [PW-1:0]       out_pid_q;
	tlfs_pkg::lvl_t      out_lvl_q;
	logic [TW-1:0]       out_quant_q;
	logic [TW-1:0]       out_elap_q;

	// process table: {blocked, level}
	logic [2:0]       lvl_mem [MAX_PROCESSES];
	logic [2:0]       lvl_rd_q;
	logic [IW-1:0]    lvl_raddr;
	logic             lvl_rd_en;
	logic             lvl_we;
	logic [IW-1:0]    lvl_waddr;
	logic [2:0]       lvl_wdata;

	tlfs_pkg::qcmd_t  qcmd;
	tlfs_pkg::qstat_t qstat;
	logic [IW-1:0]    q_push_id;
	logic [IW-1:0]    q_rd_id;

	logic             accept;
	logic             slot_free;
	logic             commit;
	logic             cfg_we;

	// commit results
	tlfs_pkg::status_t c_status;
	logic [IW-1:0]     c_id;
	tlfs_pkg::lvl_t    c_lvl;
	logic [TW-1:0]     c_quant;
	logic [TW-1:0]     c_elap;
	logic              c_run_set;
	logic              c_run_clr;
	logic              c_elap_wr;
	logic [TW-1:0]     c_elap_nxt;
	logic              c_cnt_inc;
	logic [TW-1:0]     run_quant;
	logic [TW-1:0]     elap_inc;
	logic [TW:0]       promo_sum;
	logic              pid_known;

	assign pready    = 1'b1;
	assign cfg_we    = psel && penable && pwrite && pready;
	assign s_tready  = (state_q == tlfs_pkg::S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign commit    = (state_q == tlfs_pkg::S_EXEC) && slot_free;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0000, out_elap_q, out_quant_q, out_lvl_q, out_pid_q};

	// register port
	always_comb begin
		unique case (tlfs_pkg::reg_idx_t'(paddr[2]))
			tlfs_pkg::REG_TICKS:  prdata = {8'b0, ticks_q};
			tlfs_pkg::REG_MARGIN: prdata = {6'b0, margin_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= tlfs_pkg::TICKS_RESET;
			margin_q <= tlfs_pkg::MARGIN_RESET;
		end else if (cfg_we) begin
			unique case (tlfs_pkg::reg_idx_t'(paddr[2]))
				tlfs_pkg::REG_TICKS:  ticks_q  <= pwdata[23:0];
				tlfs_pkg::REG_MARGIN: margin_q <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlfs_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		lvl_rd_en = 1'b0;
		lvl_raddr = q_rd_id;
		unique case (state_q)
			tlfs_pkg::S_IDLE: begin
				lvl_rd_en = 1'b1;
				lvl_raddr = IW'(s_tdata[PW-1:0]);
				if (accept) begin
					if (tlfs_pkg::mode_t'(s_tuser) == tlfs_pkg::MODE_DISPATCH &&
							!run_valid_q && (|qstat.nonempty)) begin
						state_nxt = tlfs_pkg::S_QREAD;
					end else begin
						state_nxt = tlfs_pkg::S_EXEC;
					end
				end
			end
			tlfs_pkg::S_QREAD: begin
				lvl_rd_en = 1'b1;
				lvl_raddr = q_rd_id;
				state_nxt = tlfs_pkg::S_EXEC;
			end
			tlfs_pkg::S_EXEC: begin
				if (commit) begin
					state_nxt = tlfs_pkg::S_IDLE;
				end
			end
			default: state_nxt = tlfs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= tlfs_pkg::mode_t'(s_tuser);
			pid_q  <= s_tdata[PW-1:0];
		end
	end

	// process table
	always_ff @(posedge clk) begin
		if (lvl_we) begin
			lvl_mem[lvl_waddr] <= lvl_wdata;
		end
		if (lvl_rd_en) begin
			lvl_rd_q <= lvl_mem[lvl_raddr];
		end
	end

	tlfs_queues #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.IW            (IW)
	) u_queues (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_tready),
		.cmd     (qcmd),
		.push_id (q_push_id),
		.rd_id   (q_rd_id),
		.stat    (qstat)
	);

	// event decode and commit
	always_comb begin
		run_quant = tlfs_pkg::quantum(ticks_q, run_lvl_q);
		elap_inc  = (elapsed_q == tlfs_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
		promo_sum = {1'b0, elapsed_q} + {1'b0, margin_q};
		pid_known = (int'(pid_q) < int'(proc_cnt_q)) && (int'(pid_q) < MAX_PROCESSES);

		c_status   = tlfs_pkg::ST_ERROR;
		c_id       = '0;
		c_lvl      = tlfs_pkg::LVL_TOP;
		c_quant    = '0;
		c_elap     = '0;
		c_run_set  = 1'b0;
		c_run_clr  = 1'b0;
		c_elap_wr  = 1'b0;
		c_elap_nxt = elap_inc;
		c_cnt_inc  = 1'b0;
		lvl_we     = 1'b0;
		lvl_waddr  = run_id_q;
		lvl_wdata  = {1'b0, run_lvl_q};
		qcmd       = '0;
		q_push_id  = run_id_q;

		unique case (mode_q)
			tlfs_pkg::MODE_ADMIT: begin
				if (proc_cnt_q != CW'(MAX_PROCESSES)) begin
					c_status      = tlfs_pkg::ST_ADMITTED;
					c_id          = IW'(proc_cnt_q);
					c_cnt_inc     = 1'b1;
					lvl_we        = 1'b1;
					lvl_waddr     = IW'(proc_cnt_q);
					lvl_wdata     = {1'b0, tlfs_pkg::LVL_TOP};
					qcmd.push     = 1'b1;
					qcmd.push_lvl = tlfs_pkg::LVL_TOP;
					q_push_id     = IW'(proc_cnt_q);
				end
			end
			tlfs_pkg::MODE_DISPATCH: begin
				if (run_valid_q) begin
					c_status = tlfs_pkg::ST_ERROR;
				end else if (!(|qstat.nonempty)) begin
					c_status = tlfs_pkg::ST_EMPTY;
				end else begin
					c_status     = tlfs_pkg::ST_DISPATCHED;
					c_id         = q_rd_id;
					c_lvl        = lvl_rd_q[1:0];
					c_quant      = tlfs_pkg::quantum(ticks_q, lvl_rd_q[1:0]);
					c_run_set    = 1'b1;
					c_elap_wr    = 1'b1;
					c_elap_nxt   = '0;
					qcmd.pop     = 1'b1;
					qcmd.pop_lvl = qstat.top_lvl;
				end
			end
			tlfs_pkg::MODE_TICK: begin
				if (!run_valid_q) begin
					c_status = tlfs_pkg::ST_NOCHANGE;
				end else begin
					c_id      = run_id_q;
					c_quant   = run_quant;
					c_elap    = elap_inc;
					c_elap_wr = 1'b1;
					if (elap_inc >= run_quant) begin
						c_status      = tlfs_pkg::ST_PREEMPTED;
						c_lvl         = (run_lvl_q == tlfs_pkg::LVL_TOP) ?
							tlfs_pkg::LVL_MID : tlfs_pkg::LVL_LOW;
						c_run_clr     = 1'b1;
						lvl_we        = 1'b1;
						lvl_wdata     = {1'b0, c_lvl};
						qcmd.push     = 1'b1;
						qcmd.push_lvl = c_lvl;
					end else begin
						c_status = tlfs_pkg::ST_NOCHANGE;
						c_lvl    = run_lvl_q;
					end
				end
			end
			tlfs_pkg::MODE_IO_START: begin
				if (run_valid_q) begin
					c_status  = tlfs_pkg::ST_BLOCKED;
					c_id      = run_id_q;
					c_quant   = run_quant;
					c_elap    = elapsed_q;
					c_run_clr = 1'b1;
					if (promo_sum < {1'b0, run_quant}) begin
						c_lvl = (run_lvl_q == tlfs_pkg::LVL_LOW) ?
							tlfs_pkg::LVL_MID : tlfs_pkg::LVL_TOP;
					end else begin
						c_lvl = run_lvl_q;
					end
					lvl_we    = 1'b1;
					lvl_wdata = {1'b1, c_lvl};
				end
			end
			tlfs_pkg::MODE_END: begin
				if (run_valid_q) begin
					c_status  = tlfs_pkg::ST_ENDED;
					c_id      = run_id_q;
					c_lvl     = run_lvl_q;
					c_quant   = run_quant;
					c_elap    = elapsed_q;
					c_run_clr = 1'b1;
				end
			end
			tlfs_pkg::MODE_IO_DONE: begin
				if (pid_known && lvl_rd_q[2]) begin
					c_status      = tlfs_pkg::ST_REQUEUED;
					c_id          = IW'(pid_q);
					c_lvl         = lvl_rd_q[1:0];
					lvl_we        = 1'b1;
					lvl_waddr     = IW'(pid_q);
					lvl_wdata     = {1'b0, lvl_rd_q[1:0]};
					qcmd.push     = 1'b1;
					qcmd.push_lvl = lvl_rd_q[1:0];
					q_push_id     = IW'(pid_q);
				end
			end
			default: ;
		endcase

		if (!commit) begin
			lvl_we = 1'b0;
			qcmd   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_id_q    <= '0;
			run_lvl_q   <= tlfs_pkg::LVL_TOP;
			elapsed_q   <= '0;
			proc_cnt_q  <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (commit) begin
				m_tvalid_q <= 1'b1;
				if (c_run_set) begin
					run_valid_q <= 1'b1;
					run_id_q    <= c_id;
					run_lvl_q   <= c_lvl;
				end else if (c_run_clr) begin
					run_valid_q <= 1'b0;
				end
				if (c_elap_wr) begin
					elapsed_q <= c_elap_nxt;
				end
				if (c_cnt_inc) begin
					proc_cnt_q <= proc_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= c_status;
			out_pid_q    <= PW'(c_id);
			out_lvl_q    <= c_lvl;
			out_quant_q  <= c_quant;
			out_elap_q   <= c_elap;
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(proc_cnt_q) <= MAX_PROCESSES)
		else $error("process count above table size");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		qcmd.push |-> !qstat.full[qcmd.push_lvl])
		else $error("push into a full level queue");

	a_disp_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && c_status == tlfs_pkg::ST_DISPATCHED) |=> run_valid_q && elapsed_q == '0)
		else $error("dispatch did not start a running process");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("event accepted while another is in flight");

endmodule
